/* rtl/core/b32pf_pkg.sv */
// Shared constants, codes, control structs and the character decoder of the prefix filter.
package b32pf_pkg;

    localparam int MAX_ENTRIES_DEF      = 256;
    localparam int FILTER_CHARS_DEF     = 51;
    localparam int MAX_PREFIX_CHARS_DEF = 55;
    localparam int KEY_BITS             = 256;
    localparam int CHAR_BITS            = 5;

    localparam logic [1:0] CMD_WRITE_CHAR = 2'd0;
    localparam logic [1:0] CMD_COMMIT     = 2'd1;
    localparam logic [1:0] CMD_LOOKUP     = 2'd2;
    localparam logic [1:0] CMD_NONE       = 2'd3;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_BAD_CHAR = 2'd1;
    localparam logic [1:0] ST_BAD_LEN  = 2'd2;
    localparam logic [1:0] ST_EMPTY    = 2'd3;

    typedef struct packed {
        logic       capture;
        logic       char_we;
        logic       cnt_we;
        logic       res_load;
        logic [1:0] res_status;
        logic       res_hit;
        logic       out_load;
    } b32pf_cmd_t;

    typedef struct packed {
        logic [1:0] command;
        logic       char_ok;
        logic       pos_ok;
        logic       ent_ok;
        logic       len_ok;
        logic       tbl_empty;
        logic       match;
        logic       out_busy;
    } b32pf_sts_t;

    // {valid, value}: a-z give 0..25, 2-7 give 26..31
    function automatic logic [5:0] b32_decode(input logic [7:0] c);
        logic [7:0] d;
        d = 8'd0;
        if (c >= 8'h61 && c <= 8'h7A)
        begin
            d = c - 8'h61;
            return {1'b1, d[4:0]};
        end
        if (c >= 8'h32 && c <= 8'h37)
        begin
            d = c - 8'h32 + 8'd26;
            return {1'b1, d[4:0]};
        end
        return {1'b0, d[4:0]};
    endfunction

endpackage

/* rtl/core/b32pf_if.sv */
// Channel interfaces of the prefix filter: request, response and configuration write.
interface b32pf_req_if import b32pf_pkg::*; ();
    logic        valid;
    logic        ready;
    logic [1:0]  command;
    logic [7:0]  entry;
    logic [5:0]  position;
    logic [7:0]  char_code;
    logic [5:0]  prefix_length;
    logic [63:0] key_word0;
    logic [63:0] key_word1;
    logic [63:0] key_word2;
    logic [63:0] key_word3;

    modport source (output valid, command, entry, position, char_code, prefix_length,
                    key_word0, key_word1, key_word2, key_word3, input ready);
    modport sink (input valid, command, entry, position, char_code, prefix_length,
                  key_word0, key_word1, key_word2, key_word3, output ready);
endinterface

interface b32pf_rsp_if import b32pf_pkg::*; ();
    logic       valid;
    logic       ready;
    logic [1:0] status;
    logic       hit;
    logic [7:0] hit_index;

    modport source (output valid, status, hit, hit_index, input ready);
    modport sink (input valid, status, hit, hit_index, output ready);
endinterface

interface b32pf_cfg_if import b32pf_pkg::*; ();
    logic       valid;
    logic       ready;
    logic [8:0] num_entries;

    modport source (output valid, num_entries, input ready);
    modport sink (input valid, num_entries, output ready);
endinterface

/* rtl/core/b32pf_dp.sv */
// Datapath of the prefix filter: table memories, field latches, matcher and result registers.
module b32pf_dp import b32pf_pkg::*; #(
    parameter int MAX_ENTRIES      = MAX_ENTRIES_DEF,
    parameter int FILTER_CHARS     = FILTER_CHARS_DEF,
    parameter int MAX_PREFIX_CHARS = MAX_PREFIX_CHARS_DEF,
    localparam int AW  = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1,
    localparam int CW  = $clog2(MAX_ENTRIES + 1),
    localparam int PCW = (FILTER_CHARS > 1) ? $clog2(FILTER_CHARS) : 1,
    localparam int NCW = $clog2(FILTER_CHARS + 1)
) (
    input  logic         clk,
    input  logic         rst_n,
    b32pf_req_if.sink    req,
    b32pf_rsp_if.source  rsp,
    b32pf_cfg_if.sink    cfg,
    input  b32pf_cmd_t   cmd,
    input  logic [AW-1:0] rd_addr,
    output b32pf_sts_t   sts,
    output logic [CW-1:0] scan_lim
);

    logic [FILTER_CHARS-1:0][CHAR_BITS-1:0] pattern_mem [MAX_ENTRIES];
    logic [NCW-1:0]                         count_mem [MAX_ENTRIES];

    logic [1:0]          cmd_reg;
    logic [7:0]          entry_reg;
    logic [5:0]          pos_reg;
    logic [7:0]          char_reg;
    logic [5:0]          len_reg;
    logic [KEY_BITS-1:0] key_reg;
    logic [8:0]          num_entries_reg;

    logic [FILTER_CHARS-1:0][CHAR_BITS-1:0] rd_row_reg;
    logic [NCW-1:0]                         rd_cnt_reg;
    logic [AW-1:0]                          rd_addr_reg;

    logic [1:0] res_status_reg;
    logic       res_hit_reg;
    logic [7:0] res_idx_reg;
    logic       out_valid_reg;
    logic [1:0] out_status_reg;
    logic       out_hit_reg;
    logic [7:0] out_idx_reg;

    logic [5:0]     dec;
    logic [31:0]    ent32;
    logic [31:0]    idx32;
    logic [AW-1:0]  wr_addr;
    logic [NCW-1:0] char_cnt;
    logic           match;

    assign dec     = b32_decode(char_reg);
    assign ent32   = 32'(entry_reg);
    assign idx32   = 32'(rd_addr_reg);
    assign wr_addr = ent32[AW-1:0];
    assign char_cnt = (32'(len_reg) > 32'(FILTER_CHARS)) ? NCW'(FILTER_CHARS) : NCW'(len_reg);

    assign scan_lim = (32'(num_entries_reg) >= 32'(MAX_ENTRIES)) ? CW'(MAX_ENTRIES)
                                                                 : CW'(num_entries_reg);

    always_comb
    begin
        match = 1'b1;
        for (int j = 0; j < FILTER_CHARS; j++)
        begin
            if ((NCW'(j) < rd_cnt_reg) &&
                (rd_row_reg[j] != key_reg[KEY_BITS-1-CHAR_BITS*j -: CHAR_BITS]))
            begin
                match = 1'b0;
            end
        end
    end

    assign sts.command   = cmd_reg;
    assign sts.char_ok   = dec[5];
    assign sts.pos_ok    = (32'(pos_reg) < 32'(FILTER_CHARS));
    assign sts.ent_ok    = (ent32 < 32'(MAX_ENTRIES));
    assign sts.len_ok    = (len_reg != 6'd0) && (32'(len_reg) <= 32'(MAX_PREFIX_CHARS));
    assign sts.tbl_empty = (num_entries_reg == 9'd0);
    assign sts.match     = match;
    assign sts.out_busy  = out_valid_reg && !rsp.ready;

    assign cfg.ready     = 1'b1;
    assign rsp.valid     = out_valid_reg;
    assign rsp.status    = out_status_reg;
    assign rsp.hit       = out_hit_reg;
    assign rsp.hit_index = out_idx_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_entries_reg <= 9'd0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                num_entries_reg <= cfg.num_entries;
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // table memories: one row read a cycle, character lane or count written
    always_ff @(posedge clk)
    begin
        rd_row_reg  <= pattern_mem[rd_addr];
        rd_cnt_reg  <= count_mem[rd_addr];
        rd_addr_reg <= rd_addr;
        if (cmd.char_we)
        begin
            pattern_mem[wr_addr][pos_reg[PCW-1:0]] <= dec[4:0];
        end
        if (cmd.cnt_we)
        begin
            count_mem[wr_addr] <= char_cnt;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            cmd_reg   <= req.command;
            entry_reg <= req.entry;
            pos_reg   <= req.position;
            char_reg  <= req.char_code;
            len_reg   <= req.prefix_length;
            key_reg   <= {req.key_word0, req.key_word1, req.key_word2, req.key_word3};
        end
        if (cmd.res_load)
        begin
            res_status_reg <= cmd.res_status;
            res_hit_reg    <= cmd.res_hit;
            res_idx_reg    <= cmd.res_hit ? idx32[7:0] : 8'd0;
        end
        if (cmd.out_load)
        begin
            out_status_reg <= res_status_reg;
            out_hit_reg    <= res_hit_reg;
            out_idx_reg    <= res_idx_reg;
        end
    end

endmodule

/* rtl/core/b32pf_ctrl.sv */
// Controller of the prefix filter: command sequencing and the table scan counters.
module b32pf_ctrl import b32pf_pkg::*; #(
    parameter int MAX_ENTRIES = MAX_ENTRIES_DEF,
    localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1,
    localparam int CW = $clog2(MAX_ENTRIES + 1)
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_ready,
    input  b32pf_sts_t    sts,
    input  logic [CW-1:0] scan_lim,
    output b32pf_cmd_t    cmd,
    output logic [AW-1:0] rd_addr
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_SCAN = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    logic [1:0]    state_reg, state_next;
    logic [CW-1:0] issue_cnt_reg, issue_cnt_next;
    logic          cmp_vld_reg, cmp_vld_next;
    logic          cmp_last_reg, cmp_last_next;
    logic          issue_stop_reg, issue_stop_next;

    assign rd_addr   = issue_cnt_reg[AW-1:0];
    assign req_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next      = state_reg;
        issue_cnt_next  = issue_cnt_reg;
        cmp_vld_next    = cmp_vld_reg;
        cmp_last_next   = cmp_last_reg;
        issue_stop_next = issue_stop_reg;
        cmd             = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_EXEC;
                end
            end
            S_EXEC:
            begin
                unique case (sts.command)
                    CMD_WRITE_CHAR:
                    begin
                        cmd.char_we    = sts.char_ok && sts.pos_ok && sts.ent_ok;
                        cmd.res_load   = 1'b1;
                        cmd.res_status = sts.char_ok ? ST_OK : ST_BAD_CHAR;
                        state_next     = S_DONE;
                    end
                    CMD_COMMIT:
                    begin
                        cmd.cnt_we     = sts.len_ok && sts.ent_ok;
                        cmd.res_load   = 1'b1;
                        cmd.res_status = sts.len_ok ? ST_OK : ST_BAD_LEN;
                        state_next     = S_DONE;
                    end
                    CMD_LOOKUP:
                    begin
                        if (sts.tbl_empty)
                        begin
                            cmd.res_load   = 1'b1;
                            cmd.res_status = ST_EMPTY;
                            state_next     = S_DONE;
                        end
                        else
                        begin
                            issue_cnt_next  = '0;
                            cmp_vld_next    = 1'b0;
                            cmp_last_next   = 1'b0;
                            issue_stop_next = 1'b0;
                            state_next      = S_SCAN;
                        end
                    end
                    CMD_NONE:
                    begin
                        cmd.res_load   = 1'b1;
                        cmd.res_status = ST_OK;
                        state_next     = S_DONE;
                    end
                    default:
                    begin
                        state_next = S_IDLE;
                    end
                endcase
            end
            S_SCAN:
            begin
                // issue one row a cycle, compare the row read the cycle before
                if (!issue_stop_reg)
                begin
                    issue_cnt_next  = issue_cnt_reg + CW'(1);
                    cmp_vld_next    = 1'b1;
                    cmp_last_next   = (issue_cnt_reg == scan_lim - CW'(1));
                    issue_stop_next = (issue_cnt_reg == scan_lim - CW'(1));
                end
                else
                begin
                    cmp_vld_next = 1'b0;
                end
                if (cmp_vld_reg && (sts.match || cmp_last_reg))
                begin
                    cmd.res_load   = 1'b1;
                    cmd.res_status = ST_OK;
                    cmd.res_hit    = sts.match;
                    state_next     = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!sts.out_busy)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            issue_cnt_reg  <= '0;
            cmp_vld_reg    <= 1'b0;
            cmp_last_reg   <= 1'b0;
            issue_stop_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            issue_cnt_reg  <= issue_cnt_next;
            cmp_vld_reg    <= cmp_vld_next;
            cmp_last_reg   <= cmp_last_next;
            issue_stop_reg <= issue_stop_next;
        end
    end

    a_one_table_write: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.char_we && cmd.cnt_we))
        else $error("character and count written together");

    a_hit_from_scan: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.res_hit |-> (state_reg == S_SCAN && cmp_vld_reg && sts.match))
        else $error("hit reported outside a valid compare");

    a_accept_to_exec: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready) |=> (state_reg == S_EXEC))
        else $error("accepted item not executed");

    a_out_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (state_reg == S_DONE && !sts.out_busy))
        else $error("result overwrites a waiting response");

endmodule

/* rtl/core/base32_prefix_bit_filter.sv */
// Top level of the base32 prefix bit filter: controller and datapath joined.
//
//  channel | modport | transfer when        | carries
//  req     | sink    | req.valid & ready    | command, entry, position, char_code,
//          |         |                      | prefix_length, key_word0..3
//  rsp     | source  | rsp.valid & ready    | status, hit, hit_index
//  cfg     | sink    | cfg.valid & ready    | num_entries (always ready)
//
// Write, commit, empty lookup and none command: the result is moved to the response
// register once that is free. Lookup: scans entries from 0 to min(num_entries,
// MAX_ENTRIES) - 1 on the single table read port, one row a cycle, to the first hit.
// A new request is taken while the previous response still waits in its register.
// Reset clears the entry count and control state; table contents hold until written.
module base32_prefix_bit_filter import b32pf_pkg::*; #(
    parameter int MAX_ENTRIES      = MAX_ENTRIES_DEF,
    parameter int FILTER_CHARS     = FILTER_CHARS_DEF,
    parameter int MAX_PREFIX_CHARS = MAX_PREFIX_CHARS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    b32pf_req_if.sink   req,
    b32pf_rsp_if.source rsp,
    b32pf_cfg_if.sink   cfg
);

    localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CW = $clog2(MAX_ENTRIES + 1);

    b32pf_cmd_t    cmd;
    b32pf_sts_t    sts;
    logic [AW-1:0] rd_addr;
    logic [CW-1:0] scan_lim;
    logic          req_ready;

    assign req.ready = req_ready;

    b32pf_ctrl #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req_ready),
        .sts       (sts),
        .scan_lim  (scan_lim),
        .cmd       (cmd),
        .rd_addr   (rd_addr)
    );

    b32pf_dp #(
        .MAX_ENTRIES      (MAX_ENTRIES),
        .FILTER_CHARS     (FILTER_CHARS),
        .MAX_PREFIX_CHARS (MAX_PREFIX_CHARS)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (req),
        .rsp      (rsp),
        .cfg      (cfg),
        .cmd      (cmd),
        .rd_addr  (rd_addr),
        .sts      (sts),
        .scan_lim (scan_lim)
    );

endmodule
